### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property on the block clock.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/edg_pkg.sv
// ----------------------------------------------------------------------------
// edg_pkg
// Widths, micro-op encoding and term tables of the equal-diagonal energy block.
// ----------------------------------------------------------------------------
package edg_pkg;

  localparam int CoordW   = 16;
  localparam int DiffW    = 17;
  localparam int DistW    = 34;
  localparam int QtyW     = 36;
  localparam int MagW     = 34;
  localparam int HalfW    = 17;
  localparam int MulAW    = 36;
  localparam int MulBW    = 18;
  localparam int ProdW    = MulAW + MulBW;
  localparam int AccW     = 72;
  localparam int GradW    = 48;
  localparam int EnergyW  = 63;
  localparam int VertW    = 16;
  localparam int GradShift   = 10;  // times 4, then Q.36 to Q.24
  localparam int EnergyShift = 24;  // Q.48 to Q.24
  localparam int InDataW  = 72;
  localparam int InUserW  = 3;
  localparam int OutDataW = 224;

  typedef logic [1:0] slot_t;
  typedef logic [1:0] qsel_t;

  localparam slot_t SLOT_B = 2'd0;
  localparam slot_t SLOT_F = 2'd1;
  localparam slot_t SLOT_Y = 2'd2;
  localparam slot_t SLOT_U = 2'd3;

  localparam qsel_t QTY_A = 2'd0;
  localparam qsel_t QTY_C = 2'd1;
  localparam qsel_t QTY_D = 2'd2;
  localparam qsel_t QTY_G = 2'd3;

  localparam logic [1:0] ROLE_FWD_Y = 2'd3;
  localparam logic [1:0] LAST_CRD   = 2'd2;
  localparam logic [1:0] LAST_TRM   = 2'd2;
  localparam logic [1:0] LAST_GRP   = 2'd3;
  localparam logic [1:0] LAST_WAIT  = 2'd3;

  typedef enum logic [1:0] {ASEL_DIFF, ASEL_QTY, ASEL_HI, ASEL_LO} asel_e;
  typedef enum logic [1:0] {BSEL_DIFF, BSEL_HI, BSEL_LO} bsel_e;
  typedef enum logic [1:0] {SH_0, SH_18, SH_34} shift_e;
  typedef enum logic [2:0] {DST_NONE, DST_DIST, DST_ENERGY, DST_GRAD, DST_EMIT} dst_e;
  typedef enum logic [2:0] {
    PH_IDLE, PH_DIST, PH_WAIT, PH_ENERGY, PH_GRAD, PH_EMIT, PH_DRAIN
  } phase_e;

  typedef struct packed {
    logic       vld;
    asel_e      asel;
    bsel_e      bsel;
    slot_t      p;
    slot_t      q;
    logic [1:0] crd;
    qsel_t      qsel;
    shift_e     sh;
    dst_e       dst;
    logic [1:0] idx;
    slot_t      vtx;
    logic       last;
  } uop_t;

  typedef struct packed {
    logic [2:0][GradW-1:0] grad;
    logic [EnergyW-1:0]    energy;
    logic                  ovf;
    slot_t                 slot;
    logic                  last;
  } emit_t;

  typedef struct packed {
    slot_t p;
    slot_t q;
    qsel_t qsel;
  } term_t;

  // Point pairs of the four squared distances: BU, FU, BY, FY.
  function automatic term_t dist_pair(input logic [1:0] d);
    term_t t;
    t.qsel = QTY_A;
    case (d)
      2'd0:    begin t.p = SLOT_B; t.q = SLOT_U; end
      2'd1:    begin t.p = SLOT_F; t.q = SLOT_U; end
      2'd2:    begin t.p = SLOT_B; t.q = SLOT_Y; end
      default: begin t.p = SLOT_F; t.q = SLOT_Y; end
    endcase
    return t;
  endfunction

  // Gradient terms: quantity times (p - q), three per vertex.
  function automatic term_t grad_term(input slot_t v, input logic [1:0] k);
    term_t t;
    case ({v, k})
      4'b00_00: t = '{SLOT_B, SLOT_Y, QTY_A};
      4'b00_01: t = '{SLOT_U, SLOT_Y, QTY_D};
      4'b00_10: t = '{SLOT_B, SLOT_U, QTY_C};
      4'b01_00: t = '{SLOT_U, SLOT_F, QTY_C};
      4'b01_01: t = '{SLOT_U, SLOT_Y, QTY_G};
      4'b01_10: t = '{SLOT_Y, SLOT_F, QTY_A};
      4'b10_00: t = '{SLOT_F, SLOT_B, QTY_A};
      4'b10_01: t = '{SLOT_Y, SLOT_B, QTY_D};
      4'b10_10: t = '{SLOT_Y, SLOT_F, QTY_G};
      4'b11_00: t = '{SLOT_F, SLOT_B, QTY_C};
      4'b11_01: t = '{SLOT_B, SLOT_U, QTY_D};
      default:  t = '{SLOT_F, SLOT_U, QTY_G};
    endcase
    return t;
  endfunction

endpackage

### src/equal_diagonal_energy_gradient.sv
// Timing: a forward-y point starts the stencil and its results then follow in order;
//   other roles are only latched into their point slots.
// Input: a forward-y point keeps the input closed until its stencil is done, since
//   all of its work runs through the single shared 36x18 multiplier.
// Reset: rst_ni clears point slots, energy, overflow flag and the sequencer.
// ----------------------------------------------------------------------------
// equal_diagonal_energy_gradient
// Streams mesh stencils and emits equal-diagonal energy and gradient results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module equal_diagonal_energy_gradient (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // vertex_index[15:0], coord_x[31:16], coord_y[47:32], coord_z[63:48],
  // pass_start[64], zero fill above
  input  logic [edg_pkg::InDataW-1:0]   s_axis_tdata,
  // func[0], role[2:1]
  input  logic [edg_pkg::InUserW-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_vertex[15:0], grad_x[63:16], grad_y[111:64], grad_z[159:112],
  // energy_total[222:160], zero fill above
  output logic [edg_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,
  // overflow[0]
  output logic                          m_axis_tuser
);
  import edg_pkg::*;

  logic [3:0][2:0][CoordW-1:0] coords_q;
  logic [3:0][VertW-1:0]       vidx_q;
  logic                        in_xfer, start, seq_busy, pipe_busy, stall;
  logic [1:0]                  role;
  uop_t                        uop;
  emit_t                       emit;
  logic                        emit_vld, out_load;
  logic                        out_vld_q, out_vld_d;
  logic [OutDataW-1:0]         out_data_q;
  logic                        out_last_q, out_ovf_q;

  // Input side: take a point only while no stencil is being worked on.
  assign s_axis_tready = !seq_busy;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign role          = s_axis_tuser[2:1];
  assign start         = in_xfer && (role == ROLE_FWD_Y);

  // Point slots, indexed by role. Missing points keep their old contents.
  // The vertex index range equals the field width, so no reduction is needed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coords_q <= '0;
      vidx_q   <= '0;
    end else if (in_xfer) begin
      vidx_q[role]      <= s_axis_tdata[15:0];
      coords_q[role][0] <= s_axis_tdata[31:16];
      coords_q[role][1] <= s_axis_tdata[47:32];
      coords_q[role][2] <= s_axis_tdata[63:48];
    end
  end

  edg_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .boundary_i  (s_axis_tuser[0]),
    .stall_i     (stall),
    .pipe_busy_i (pipe_busy),
    .uop_o       (uop),
    .busy_o      (seq_busy)
  );

  edg_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .uop_i        (uop),
    .stall_i      (stall),
    .energy_clr_i (in_xfer && s_axis_tdata[64]),
    .coords_i     (coords_q),
    .emit_o       (emit),
    .emit_vld_o   (emit_vld),
    .busy_o       (pipe_busy)
  );

  // Freeze the whole pipeline while a result waits on a full output register.
  assign stall    = emit_vld && out_vld_q && !m_axis_tready;
  assign out_load = emit_vld && !stall;

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  // Output payload: hold until the next result is loaded.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {1'b0, emit.energy, emit.grad[2], emit.grad[1], emit.grad[0],
                     vidx_q[emit.slot]};
      out_last_q <= emit.last;
      out_ovf_q  <= emit.ovf;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_ovf_q;

  // A completing point must close the input until its stencil is done.
  `ASSERT_NEXT(a_start_blocks, start, !s_axis_tready, "input open after stencil start")
  // Slots must not change while products still read them.
  `ASSERT_CLK(a_no_accept_busy, !(s_axis_tready && pipe_busy), "input open with busy pipe")
  // The forward-y vertex, and only it, closes a stencil.
  `ASSERT_CLK(a_last_on_u, !emit_vld || (emit.last == (emit.slot == SLOT_U)),
              "stencil end flag on wrong vertex")

endmodule

### src/edg_seq.sv
// ----------------------------------------------------------------------------
// edg_seq
// Micro-op sequencer: walks distances, energy terms and gradient terms.
// ----------------------------------------------------------------------------
module edg_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          boundary_i,
  input  logic          stall_i,
  input  logic          pipe_busy_i,
  output edg_pkg::uop_t uop_o,
  output logic          busy_o
);
  import edg_pkg::*;

  phase_e     ph_q, ph_d;
  logic [1:0] grp_q, grp_d, crd_q, crd_d, trm_q, trm_d;
  logic       bnd_q, bnd_d;
  term_t      dt, gt;
  logic       skip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_IDLE;
      grp_q <= '0;
      crd_q <= '0;
      trm_q <= '0;
      bnd_q <= 1'b0;
    end else begin
      ph_q  <= ph_d;
      grp_q <= grp_d;
      crd_q <= crd_d;
      trm_q <= trm_d;
      bnd_q <= bnd_d;
    end
  end

  // Next state.
  always_comb begin
    ph_d  = ph_q;
    grp_d = grp_q;
    crd_d = crd_q;
    trm_d = trm_q;
    bnd_d = bnd_q;
    if (!stall_i) begin
      case (ph_q)
        PH_IDLE: begin
          if (start_i) begin
            ph_d  = PH_DIST;
            grp_d = '0;
            crd_d = '0;
            trm_d = '0;
            bnd_d = boundary_i;
          end
        end
        PH_DIST: begin
          if (crd_q == LAST_CRD) begin
            crd_d = '0;
            if (grp_q == LAST_GRP) begin
              ph_d  = PH_WAIT;
              grp_d = '0;
            end else begin
              grp_d = grp_q + 2'd1;
            end
          end else begin
            crd_d = crd_q + 2'd1;
          end
        end
        PH_WAIT: begin
          if (crd_q == LAST_WAIT) begin
            ph_d  = PH_ENERGY;
            crd_d = '0;
          end else begin
            crd_d = crd_q + 2'd1;
          end
        end
        PH_ENERGY: begin
          if (trm_q == LAST_TRM) begin
            trm_d = '0;
            if (grp_q == LAST_GRP) begin
              ph_d  = PH_GRAD;
              grp_d = '0;
            end else begin
              grp_d = grp_q + 2'd1;
            end
          end else begin
            trm_d = trm_q + 2'd1;
          end
        end
        // All vertices first, so the overflow flag covers every gradient.
        PH_GRAD: begin
          if (trm_q == LAST_TRM) begin
            trm_d = '0;
            if (crd_q == LAST_CRD) begin
              crd_d = '0;
              if (grp_q == LAST_GRP) begin
                grp_d = '0;
                ph_d  = PH_EMIT;
              end else begin
                grp_d = grp_q + 2'd1;
              end
            end else begin
              crd_d = crd_q + 2'd1;
            end
          end else begin
            trm_d = trm_q + 2'd1;
          end
        end
        PH_EMIT: begin
          if (grp_q == LAST_GRP) begin
            ph_d = PH_DRAIN;
          end else begin
            grp_d = grp_q + 2'd1;
          end
        end
        PH_DRAIN: begin
          if (!pipe_busy_i) ph_d = PH_IDLE;
        end
        default: ph_d = PH_IDLE;
      endcase
    end
  end

  assign dt = dist_pair(grp_q);
  assign gt = grad_term(grp_q, trm_q);

  // Boundary gradient steps outside the C terms multiply C by a zero difference,
  // so the sum still closes on its last step.
  assign skip = bnd_q && (gt.qsel != QTY_C);

  // Micro-op outputs; boundary stencils turn star-only steps into bubbles.
  always_comb begin
    uop_o      = '0;
    uop_o.asel = ASEL_DIFF;
    uop_o.bsel = BSEL_DIFF;
    uop_o.sh   = SH_0;
    uop_o.dst  = DST_NONE;
    case (ph_q)
      PH_DIST: begin
        uop_o.vld = !(bnd_q && grp_q[1]);
        uop_o.p   = dt.p;
        uop_o.q   = dt.q;
        uop_o.crd = crd_q;
        uop_o.idx = grp_q;
        uop_o.dst = (crd_q == LAST_CRD) ? DST_DIST : DST_NONE;
      end
      PH_ENERGY: begin
        uop_o.vld  = !(bnd_q && grp_q != QTY_C);
        uop_o.qsel = grp_q;
        uop_o.asel = (trm_q == LAST_TRM) ? ASEL_LO : ASEL_HI;
        uop_o.bsel = (trm_q == 2'd0) ? BSEL_HI : BSEL_LO;
        case (trm_q)
          2'd0:    uop_o.sh = SH_34;
          2'd1:    uop_o.sh = SH_18;
          default: uop_o.sh = SH_0;
        endcase
        uop_o.dst = (trm_q == LAST_TRM) ? DST_ENERGY : DST_NONE;
      end
      PH_GRAD: begin
        uop_o.vld  = !(bnd_q && grp_q == SLOT_Y);
        uop_o.asel = ASEL_QTY;
        uop_o.p    = gt.p;
        uop_o.q    = skip ? gt.p : gt.q;
        uop_o.qsel = skip ? QTY_C : gt.qsel;
        uop_o.crd  = crd_q;
        uop_o.idx  = crd_q;
        uop_o.vtx  = grp_q;
        uop_o.dst  = (trm_q == LAST_TRM) ? DST_GRAD : DST_NONE;
      end
      PH_EMIT: begin
        uop_o.vld  = !(bnd_q && grp_q == SLOT_Y);
        uop_o.dst  = DST_EMIT;
        uop_o.idx  = grp_q;
        uop_o.last = (grp_q == SLOT_U);
      end
      default: uop_o = uop_o;
    endcase
  end

  assign busy_o = (ph_q != PH_IDLE);

endmodule

### src/edg_dp.sv
// ----------------------------------------------------------------------------
// edg_dp
// Shared multiply-accumulate unit with distance, energy and gradient registers.
// ----------------------------------------------------------------------------
module edg_dp (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  edg_pkg::uop_t                             uop_i,
  input  logic                                      stall_i,
  input  logic                                      energy_clr_i,
  input  logic [3:0][2:0][edg_pkg::CoordW-1:0]     coords_i,
  output edg_pkg::emit_t                            emit_o,
  output logic                                      emit_vld_o,
  output logic                                      busy_o
);
  import edg_pkg::*;

  localparam logic [AccW-1:0] GradMaxA = AccW'({1'b0, {(GradW-1){1'b1}}});
  localparam logic [AccW-1:0] GradMinA = ~GradMaxA;
  localparam logic [EnergyW:0] EnergyMax = {1'b0, {EnergyW{1'b1}}};

  uop_t                     op1_q, op2_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [AccW-1:0]   acc_q, acc_d, term, base;
  logic [3:0][DistW-1:0]    dist_q;
  logic [3:0][QtyW-1:0]     qty_q;
  logic [3:0][MagW-1:0]     mag_q;
  logic [EnergyW-1:0]       energy_q;
  logic                     sat_q;
  logic [3:0][2:0][GradW-1:0] grad_q;

  logic signed [CoordW-1:0] cp, cq;
  logic signed [DiffW-1:0]  diff;
  logic [MagW-1:0]          mag;
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [AccW-1:0]   prod_x, gsh;
  logic [EnergyW:0]         esum;
  logic                     consume;

  function automatic logic [CoordW-1:0] pick(input logic [2:0][CoordW-1:0] pt,
                                             input logic [1:0] c);
    case (c)
      2'd0:    return pt[0];
      2'd1:    return pt[1];
      default: return pt[2];
    endcase
  endfunction

  // Operand select and multiply.
  assign cp   = pick(coords_i[uop_i.p], uop_i.crd);
  assign cq   = pick(coords_i[uop_i.q], uop_i.crd);
  assign diff = DiffW'(cp) - DiffW'(cq);
  assign mag  = mag_q[uop_i.qsel];

  always_comb begin
    case (uop_i.asel)
      ASEL_QTY: mul_a = qty_q[uop_i.qsel];
      ASEL_HI:  mul_a = MulAW'(mag[MagW-1:HalfW]);
      ASEL_LO:  mul_a = MulAW'(mag[HalfW-1:0]);
      default:  mul_a = MulAW'(diff);
    endcase
    case (uop_i.bsel)
      BSEL_HI: mul_b = MulBW'(mag[MagW-1:HalfW]);
      BSEL_LO: mul_b = MulBW'(mag[HalfW-1:0]);
      default: mul_b = MulBW'(diff);
    endcase
  end

  // Accumulate: a finishing step in the last stage hands the next sum a zero base.
  assign consume = op2_q.vld && (op2_q.dst == DST_DIST || op2_q.dst == DST_ENERGY ||
                                 op2_q.dst == DST_GRAD);
  assign prod_x  = AccW'(prod_q);
  always_comb begin
    case (op1_q.sh)
      SH_18:   term = prod_x <<< 18;
      SH_34:   term = prod_x <<< 34;
      default: term = prod_x;
    endcase
    if (!op1_q.vld) term = '0;
    base  = consume ? '0 : acc_q;
    acc_d = base + term;
  end

  assign gsh  = acc_q >>> GradShift;
  assign esum = {1'b0, energy_q} + (EnergyW+1)'(acc_q[AccW-1:EnergyShift]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op1_q    <= '0;
      op2_q    <= '0;
      acc_q    <= '0;
      energy_q <= '0;
      sat_q    <= 1'b0;
    end else begin
      if (!stall_i) begin
        op1_q <= uop_i;
        op2_q <= op1_q;
        acc_q <= acc_d;
      end
      if (energy_clr_i) begin
        energy_q <= '0;
        sat_q    <= 1'b0;
      end else if (!stall_i && op2_q.vld) begin
        if (op2_q.dst == DST_ENERGY) begin
          if (esum > EnergyMax) begin
            energy_q <= EnergyMax[EnergyW-1:0];
            sat_q    <= 1'b1;
          end else begin
            energy_q <= esum[EnergyW-1:0];
          end
        end else if (op2_q.dst == DST_GRAD) begin
          if ($signed(gsh) > $signed(GradMaxA) || $signed(gsh) < $signed(GradMinA)) begin
            sat_q <= 1'b1;
          end
        end
      end
    end
  end

  // Payload registers; qty is registered from the distances, and magnitude from qty.
  always_ff @(posedge clk_i) begin
    if (!stall_i) prod_q <= mul_a * mul_b;
    if (!stall_i && op2_q.vld && op2_q.dst == DST_DIST) begin
      dist_q[op2_q.idx] <= acc_q[DistW-1:0];
    end
    if (!stall_i && op2_q.vld && op2_q.dst == DST_GRAD) begin
      if ($signed(gsh) > $signed(GradMaxA)) begin
        grad_q[op2_q.vtx][op2_q.idx] <= GradMaxA[GradW-1:0];
      end else if ($signed(gsh) < $signed(GradMinA)) begin
        grad_q[op2_q.vtx][op2_q.idx] <= GradMinA[GradW-1:0];
      end else begin
        grad_q[op2_q.vtx][op2_q.idx] <= gsh[GradW-1:0];
      end
    end
    qty_q[QTY_A] <= QtyW'(dist_q[2]) - QtyW'(dist_q[3]);
    qty_q[QTY_C] <= QtyW'(dist_q[0]) - QtyW'(dist_q[1]);
    qty_q[QTY_D] <= QtyW'(dist_q[2]) - QtyW'(dist_q[0]);
    qty_q[QTY_G] <= QtyW'(dist_q[3]) - QtyW'(dist_q[1]);
    for (int i = 0; i < 4; i++) begin
      mag_q[i] <= qty_q[i][QtyW-1] ? MagW'(-qty_q[i]) : qty_q[i][MagW-1:0];
    end
  end

  assign emit_vld_o    = op2_q.vld && (op2_q.dst == DST_EMIT);
  assign emit_o.grad   = grad_q[op2_q.idx];
  assign emit_o.energy = energy_q;
  assign emit_o.ovf    = sat_q;
  assign emit_o.slot   = op2_q.idx;
  assign emit_o.last   = op2_q.last;
  assign busy_o        = op1_q.vld || op2_q.vld;

endmodule
